// ----- rtl/spq_pkg.sv -----
// Package for the sorted priority queue: capacity, field widths, status codes,
// and the types shared by the cell chain, the top level and the checker.
// Depends on nothing.
package spq_pkg;

   // Number of cells in the chain (range 2 to 31, as the fill count field is FILL_W bits).
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths.
   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;
   localparam int FILL_W  = 5;
   localparam int STAT_W  = 2;

   // Packed stream widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // Action codes carried in req_tuser.
   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_SERVE  = 1'b1
   } action_type;

   // Result status codes.
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } entry_type;

   // Per-cycle control seen by one cell.
   typedef struct packed {
      logic insert;      // an insert is taking place this cycle
      logic serve;       // a serve is taking place this cycle
      logic occupied;    // this cell holds a live entry
      logic left_after;  // the new entry goes after the left neighbor's entry
   } cell_ctrl_type;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue, lowest priority number served first, ties first in first out.
// The result item of an accepted item is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle while the consumer takes results; every cell of the chain compares and shifts at once.
// Reset (synchronous, active high) empties the queue and drops any pending result.
// Cell contents are not reset; only cells below the fill count are ever read.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [spq_pkg::REQ_DATA_W-1:0]     req_tdata,  // item_value[31:0], item_priority[47:32]
   input  logic                               req_tuser,  // action[0]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [spq_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // served_value[31:0], fill_count[36:32], zero
   output logic [spq_pkg::RSP_USER_W-1:0]     rsp_tuser   // served_valid[0], status[2:1]
);
   import spq_pkg::*;

   logic                     req_accept;
   logic                     do_insert;
   logic                     do_serve;
   logic                     is_full;
   logic                     is_empty;
   entry_type                new_entry;
   entry_type                cell_entry [CAPACITY];
   logic [CAPACITY-1:0]      cell_after;
   cell_ctrl_type            cell_ctrl  [CAPACITY];

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_in;
   logic [RSP_USER_W-1:0]    rsp_user_ff;
   logic [RSP_USER_W-1:0]    rsp_user_in;
   logic signed [VALUE_W-1:0] served_value;
   logic                     served_valid;
   status_type               status;
   logic [FILL_W+CNT_W-1:0]  fill_wide;
   logic [FILL_W-1:0]        fill_count;

   // An item is taken whenever the output register is free or being emptied.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign new_entry.value = req_tdata[VALUE_W-1:0];
   assign new_entry.prio  = req_tdata[VALUE_W+PRIO_W-1:VALUE_W];

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign do_insert = req_accept && (req_tuser == ACT_INSERT) && !is_full;
   assign do_serve  = req_accept && (req_tuser == ACT_SERVE) && !is_empty;

   // The chain of cells; the first cell sees a virtual left neighbor that the
   // new entry always follows, the last cell refills from itself on a serve.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_ctrl[i].insert     = do_insert;
      assign cell_ctrl[i].serve      = do_serve;
      assign cell_ctrl[i].occupied   = (CNT_W'(i) < count_ff);
      assign cell_ctrl[i].left_after = (i == 0) ? 1'b1 : cell_after[(i == 0) ? 0 : i-1];

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .new_entry   (new_entry),
         .left_entry  (cell_entry[(i == 0) ? 0 : i-1]),
         .right_entry (cell_entry[(i == CAPACITY-1) ? i : i+1]),
         .entry       (cell_entry[i]),
         .after       (cell_after[i])
      );
   end

   // Fill count follows the inserts and serves that really change the queue.
   always_comb begin
      count_in = count_ff;
      priority if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_serve) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Build the result item for the accepted input item.
   always_comb begin
      served_value = '0;
      served_valid = 1'b0;
      status       = ST_OK;
      if (req_tuser == ACT_SERVE) begin
         if (is_empty) begin
            status = ST_EMPTY;
         end else begin
            served_value = cell_entry[0].value;
            served_valid = 1'b1;
         end
      end else if (is_full) begin
         status = ST_FULL;
      end
      fill_wide   = {{FILL_W{1'b0}}, count_in};
      fill_count  = fill_wide[FILL_W-1:0];
      rsp_data_in = {{(RSP_DATA_W-VALUE_W-FILL_W){1'b0}}, fill_count, served_value};
      rsp_user_in = {status, served_valid};
   end

   // Output register holds a result until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/spq_cell.sv -----
// One cell of the sorted queue chain: holds one entry and, on each item,
// keeps it, takes the new entry, or takes the entry of its left or right neighbor.
// Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  spq_pkg::entry_type    new_entry,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry,
   output logic                  after
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The new entry belongs behind this one when this entry's priority is
   // less than or equal to it, which keeps equal priorities in arrival order.
   assign after = ctrl.occupied && (entry_ff.prio <= new_entry.prio);

   // Select the next content of the cell.
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         priority if (after) begin
            entry_in = entry_ff;
         end else if (ctrl.left_after) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.serve) begin
         entry_in = right_entry;
      end
   end

   // Entry storage needs no reset; only cells below the fill count are read.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [spq_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [spq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [spq_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import spq_pkg::*;

   logic [FILL_W-1:0] fill_count;
   logic [STAT_W-1:0] status;
   logic              served_valid;

   assign fill_count   = rsp_tdata[VALUE_W+FILL_W-1:VALUE_W];
   assign status       = rsp_tuser[STAT_W:1];
   assign served_valid = rsp_tuser[0];

   // A result that waits keeps its content.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // Every accepted item leaves a result in the output register.
   a_item_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item produced no result item");

   // A serve on an empty queue leaves it empty.
   a_empty_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_EMPTY) |-> (fill_count == '0) && !served_valid)
      else $error("empty status with nonzero fill count");

   // A dropped insert only happens at capacity.
   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_FULL) |-> (fill_count == FILL_W'(CAPACITY)) && !served_valid)
      else $error("full status below capacity");

   // A served entry always comes with an ok status.
   a_served_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && served_valid |-> (status == ST_OK))
      else $error("served entry with error status");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

// ----- bench/sorted_priority_queue_test.sv -----
// Self-checking testbench for sorted_priority_queue: directed and random insert/serve items,
// with random stalls on both stream sides, checked against a behavioral queue model.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int RANDOM_ITEMS = 1200;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_REPORTS  = 10;

   // One input item as the driver sends it.
   typedef struct {
      action_type                act;
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } request_type;

   // One result item as the block should return it.
   typedef struct {
      logic signed [VALUE_W-1:0] served_value;
      logic                      served_valid;
      status_type                status;
      logic [FILL_W-1:0]         fill_count;
   } result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // item_value[31:0], item_priority[47:32]
   logic                  req_tuser  = 1'b0;  // action[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // served_value[31:0], fill_count[36:32], zero
   logic [RSP_USER_W-1:0] rsp_tuser;  // served_valid[0], status[2:1]

   request_type pending_requests[$];
   request_type next_request;
   result_type  expected_results[$];
   entry_type   queue_contents[$];
   result_type  predicted;
   result_type  observed;

   int items_loaded  = 0;
   int quiet_cycles  = 0;
   int fail_count    = 0;
   int send_idle_pct;
   int recv_stall_pct;
   logic activity;

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one item to the behavioral queue and returns the result it causes.
   // Inserts go behind every stored entry of lower or equal priority number.
   function automatic result_type apply_queue_item(action_type act,
                                                   logic signed [VALUE_W-1:0] value,
                                                   logic [PRIO_W-1:0] prio);
      result_type res;
      entry_type  fresh;
      int         pos;
      res.served_value = '0;
      res.served_valid = 1'b0;
      res.status       = ST_OK;
      if (act == ACT_INSERT) begin
         if (queue_contents.size() >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < queue_contents.size() && queue_contents[pos].prio <= prio)
               pos++;
            fresh.value = value;
            fresh.prio  = prio;
            queue_contents.insert(pos, fresh);
         end
      end else if (queue_contents.size() == 0) begin
         res.status = ST_EMPTY;
      end else begin
         res.served_value = queue_contents[0].value;
         res.served_valid = 1'b1;
         void'(queue_contents.pop_front());
      end
      res.fill_count = FILL_W'(queue_contents.size());
      return res;
   endfunction

   task automatic add_insert(logic signed [VALUE_W-1:0] value, logic [PRIO_W-1:0] prio);
      request_type req;
      req.act   = ACT_INSERT;
      req.value = value;
      req.prio  = prio;
      pending_requests.push_back(req);
   endtask

   // Serve items carry random content in the ignored fields.
   task automatic add_serve();
      request_type req;
      req.act   = ACT_SERVE;
      req.value = $urandom;
      req.prio  = PRIO_W'($urandom);
      pending_requests.push_back(req);
   endtask

   // Picks a priority: mostly a narrow range so that ties are common.
   function automatic logic [PRIO_W-1:0] pick_priority();
      int roll;
      roll = $urandom_range(9);
      if (roll < 6)
         return PRIO_W'($urandom_range(7));
      else if (roll < 8)
         return PRIO_W'($urandom);
      else if (roll == 8)
         return '0;
      else
         return '1;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0)
         return 32'sh7FFF_FFFF;
      else if (roll == 1)
         return 32'sh8000_0000;
      else
         return $urandom;
   endfunction

   // Idle rates per phase of the run: sender light and receiver heavy,
   // then the other way round, then no idling at all.
   always_comb begin
      if (items_loaded < 420) begin
         send_idle_pct  = 14;
         recv_stall_pct = 75;
      end else if (items_loaded < 840) begin
         send_idle_pct  = 75;
         recv_stall_pct = 14;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   end

   // Driver: loads the next pending item once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            next_request = pending_requests.pop_front();
            req_tvalid   <= 1'b1;
            req_tdata    <= {next_request.prio, next_request.value};
            req_tuser    <= next_request.act;
            items_loaded <= items_loaded + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: checks each result item against the oldest expectation, then
   // predicts the result of any input item taken at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         activity = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            activity              = 1'b1;
            observed.served_value = rsp_tdata[VALUE_W-1:0];
            observed.fill_count   = rsp_tdata[VALUE_W +: FILL_W];
            observed.served_valid = rsp_tuser[0];
            observed.status       = status_type'(rsp_tuser[STAT_W:1]);
            if (expected_results.size() == 0) begin
               if (fail_count < MAX_REPORTS)
                  $display("%0t: unexpected result item value=%0d valid=%0b status=%0d fill=%0d",
                           $realtime, observed.served_value, observed.served_valid,
                           observed.status, observed.fill_count);
               fail_count++;
            end else begin
               predicted = expected_results.pop_front();
               if (observed.served_value !== predicted.served_value ||
                   observed.served_valid !== predicted.served_valid ||
                   observed.status       !== predicted.status ||
                   observed.fill_count   !== predicted.fill_count) begin
                  if (fail_count < MAX_REPORTS) begin
                     $write("%0t: mismatch: expected value=%0d valid=%0b status=%0d fill=%0d,",
                            $realtime, predicted.served_value, predicted.served_valid,
                            predicted.status, predicted.fill_count);
                     $display(" got value=%0d valid=%0b status=%0d fill=%0d",
                              observed.served_value, observed.served_valid,
                              observed.status, observed.fill_count);
                  end
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            activity = 1'b1;
            expected_results.push_back(apply_queue_item(action_type'(req_tuser),
                                                        req_tdata[VALUE_W-1:0],
                                                        req_tdata[VALUE_W +: PRIO_W]));
         end
         quiet_cycles <= activity ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   initial begin
      while (quiet_cycles < STALL_LIMIT)
         @(negedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Stimulus, reset and end of run.
   initial begin
      int burst_len;
      int insert_pct;
      int produced;

      // Serve on an empty queue first.
      add_serve();
      // Fill to capacity with extreme values, extreme priorities and ties.
      add_insert(32'sh7FFF_FFFF, 16'hFFFF);
      add_insert(32'sh8000_0000, 16'h0000);
      add_insert(32'sd1, 16'd100);
      add_insert(32'sd2, 16'd100);
      add_insert(32'sd3, 16'd100);
      add_insert(32'sd0, 16'h0000);
      add_insert(-32'sd1, 16'hFFFF);
      add_insert(32'sh5555_AAAA, 16'h5A5A);
      add_insert(32'shAAAA_5555, 16'hA5A5);
      for (int k = 0; k < CAPACITY - 9; k++)
         add_insert($urandom, 16'd7);
      // Insert on a full queue is dropped.
      add_insert(32'sd99, 16'h0000);
      repeat (5) add_serve();

      // Random bursts with a varying insert rate, so the queue swings
      // between empty and full.
      produced = 0;
      while (produced < RANDOM_ITEMS) begin
         case ($urandom_range(2))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
         endcase
         burst_len = $urandom_range(10, 60);
         for (int k = 0; k < burst_len && produced < RANDOM_ITEMS; k++) begin
            if ($urandom_range(99) < insert_pct)
               add_insert(pick_value(), pick_priority());
            else
               add_serve();
            produced++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item is sent and every result has come back.
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (10) @(negedge clock);

      if (fail_count == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
